// ===== hw/rtl/pss_pkg.sv =====
// Shared types and constants for the plucked-string synth core.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package pss_pkg;

	// Delay ring geometry. The depth is a power of two so that the index wraps by truncation.
	localparam int RING_DEPTH = 256;
	localparam int IDX_W      = $clog2(RING_DEPTH);

	// Phase accumulator: 16-bit wrapping sum, FRAC_BITS of it below the index point.
	localparam int PHASE_W    = 16;
	localparam int FRAC_BITS  = 14;

	// One step moves the index by at most NUM_BANKS-1 entries, so the ring is split
	// into NUM_BANKS banks by the low index bits and every step touches distinct banks.
	localparam int BANK_W     = PHASE_W - FRAC_BITS;
	localparam int NUM_BANKS  = 1 << BANK_W;
	localparam int ROWS       = RING_DEPTH / NUM_BANKS;
	localparam int ROW_W      = IDX_W - BANK_W;

	localparam int SAMPLE_W   = 8;
	localparam int ATTACK_W   = 16;
	localparam int ADDR_W     = 8;

	// Scaled output: (raw >> PCM_SHIFT) + PCM_OFFSET.
	localparam int                PCM_SHIFT  = 4;
	localparam logic [SAMPLE_W-1:0] PCM_OFFSET = SAMPLE_W'(127);

	// Operation codes.
	localparam logic [1:0] OP_STEP  = 2'd0;
	localparam logic [1:0] OP_HOLD  = 2'd1;
	localparam logic [1:0] OP_PLUCK = 2'd2;
	localparam logic [1:0] OP_LOAD  = 2'd3;

	typedef struct packed {
		logic [1:0]          operation;
		logic [PHASE_W-1:0]  step_period;
		logic [ATTACK_W-1:0] attack_length;
		logic [ADDR_W-1:0]   table_address;
		logic [SAMPLE_W-1:0] table_value;
	} cmd_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_raw;
		logic [SAMPLE_W-1:0] sample_pcm;
	} sample_t;

	// One write into the delay ring.
	typedef struct packed {
		logic                en;
		logic [IDX_W-1:0]    pos;
		logic [SAMPLE_W-1:0] data;
	} ring_wr_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pss_ring.sv =====
// Banked delay ring with per-entry valid bits and a look-ahead read of every bank.
// Depends on pss_pkg for geometry and the ring_wr_t write type.
`default_nettype none

module pss_ring (
	input  wire logic                                          clk,
	input  wire logic                                          arst_n,
	input  wire logic [pss_pkg::IDX_W-1:0]                     rd_base,
	input  pss_pkg::ring_wr_t                                  wr_a,
	input  pss_pkg::ring_wr_t                                  wr_b,
	output logic [pss_pkg::NUM_BANKS-1:0][pss_pkg::SAMPLE_W-1:0] rd_data
);
	import pss_pkg::*;

	logic [SAMPLE_W-1:0] mem [NUM_BANKS][ROWS];
	logic [RING_DEPTH-1:0] valid_q;

	logic [NUM_BANKS-1:0][IDX_W-1:0]    rd_pos;
	logic [NUM_BANKS-1:0]               bank_we;
	logic [NUM_BANKS-1:0][ROW_W-1:0]    bank_wrow;
	logic [NUM_BANKS-1:0][SAMPLE_W-1:0] bank_wdata;
	logic [NUM_BANKS-1:0][SAMPLE_W-1:0] rd_q;
	logic [NUM_BANKS-1:0]               rd_valid_q;

	// Each bank reads the one entry among rd_base+1 .. rd_base+NUM_BANKS that lives in it.
	always_comb begin
		logic [BANK_W-1:0] off;
		for (int b = 0; b < NUM_BANKS; b++) begin
			off       = BANK_W'(b) - rd_base[BANK_W-1:0] - BANK_W'(1);
			rd_pos[b] = rd_base + IDX_W'(off) + IDX_W'(1);
		end
	end

	// Route the two write ports; they never target the same bank in one cycle.
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			bank_we[b]    = 1'b0;
			bank_wrow[b]  = wr_a.pos[IDX_W-1:BANK_W];
			bank_wdata[b] = wr_a.data;
			if (wr_a.en && wr_a.pos[BANK_W-1:0] == BANK_W'(b)) begin
				bank_we[b] = 1'b1;
			end else if (wr_b.en && wr_b.pos[BANK_W-1:0] == BANK_W'(b)) begin
				bank_we[b]    = 1'b1;
				bank_wrow[b]  = wr_b.pos[IDX_W-1:BANK_W];
				bank_wdata[b] = wr_b.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			if (bank_we[b]) begin
				mem[b][bank_wrow[b]] <= bank_wdata[b];
			end
			rd_q[b] <= mem[b][rd_pos[b][IDX_W-1:BANK_W]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= '0;
		end else begin
			if (wr_a.en) begin
				valid_q[wr_a.pos] <= 1'b1;
			end
			if (wr_b.en) begin
				valid_q[wr_b.pos] <= 1'b1;
			end
			for (int b = 0; b < NUM_BANKS; b++) begin
				rd_valid_q[b] <= valid_q[rd_pos[b]];
			end
		end
	end

	// Never-written entries read as zero.
	always_comb begin
		for (int b = 0; b < NUM_BANKS; b++) begin
			rd_data[b] = rd_valid_q[b] ? rd_q[b] : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/plucked_string_synth_core.sv =====
// Plucked-string (Karplus-Strong) voice: request decode, step datapath and output skid.
// Depends on pss_pkg and pss_ring.
// Output: a step or hold sample is registered in the head, or in the skid if the head stalls.
// Throughput: one request per cycle while the skid is empty; a skid absorbs a stall.
// Reset: index, phase, attack count, current entry and output valids clear at once; the ring
//   reads as zero through per-entry valid bits, so no clearing pass is needed.
`default_nettype none

module plucked_string_synth_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_ready,
	input  pss_pkg::cmd_t   cmd,
	output logic            sample_valid,
	input  wire logic       sample_ready,
	output pss_pkg::sample_t sample
);
	import pss_pkg::*;

	// Voice state. cur_q mirrors the ring entry at the current index.
	logic [IDX_W-1:0]    idx_q;
	logic [FRAC_BITS-1:0] phase_q;
	logic [ATTACK_W-1:0] attack_q;
	logic [SAMPLE_W-1:0] cur_q;

	// Excitation table, written by load requests and read through a register at the next index.
	logic [SAMPLE_W-1:0] exc_mem [RING_DEPTH];
	logic [SAMPLE_W-1:0] exc_rd_q;

	// Output stage: head register plus one skid entry.
	sample_t out_q;
	logic    out_valid_q;
	sample_t skid_q;
	logic    skid_valid_q;

	logic                accept;
	logic                do_step;
	logic                do_hold;
	logic                do_pluck;
	logic                do_load;
	logic [PHASE_W-1:0]  phase_sum;
	logic [BANK_W-1:0]   carry;
	logic [IDX_W-1:0]    step_idx;
	logic [IDX_W-1:0]    idx_d;
	logic [IDX_W-1:0]    ld_addr;
	logic                attack_on;
	logic [SAMPLE_W-1:0] x_val;
	logic [SAMPLE_W-1:0] next_val;
	logic [SAMPLE_W:0]   avg_sum;
	logic [SAMPLE_W-1:0] new_cur;
	logic [SAMPLE_W-1:0] res_raw;
	sample_t             res;
	logic                push;
	logic                head_free;
	ring_wr_t            wr_a;
	ring_wr_t            wr_b;
	logic [NUM_BANKS-1:0][SAMPLE_W-1:0] ring_rd;

	assign cmd_ready = !skid_valid_q;
	assign accept    = cmd_valid && cmd_ready;

	// Decode the request.
	always_comb begin
		do_step  = 1'b0;
		do_hold  = 1'b0;
		do_pluck = 1'b0;
		do_load  = 1'b0;
		unique case (cmd.operation)
			OP_STEP:  do_step  = accept;
			OP_HOLD:  do_hold  = accept;
			OP_PLUCK: do_pluck = accept;
			OP_LOAD:  do_load  = accept;
			default:  do_step  = 1'b0;
		endcase
	end

	// Advance the phase; the bits above the fraction move the index.
	assign phase_sum = {{(PHASE_W-FRAC_BITS){1'b0}}, phase_q} + cmd.step_period;
	assign carry     = phase_sum[PHASE_W-1:FRAC_BITS];
	assign step_idx  = idx_q + IDX_W'(carry);
	assign idx_d     = do_step ? step_idx : idx_q;
	assign ld_addr   = IDX_W'(cmd.table_address);

	// During the attack the step copies the excitation entry in before reading it.
	assign attack_on = (attack_q != '0);
	assign x_val     = attack_on ? exc_rd_q : cur_q;

	// The entry at the new index comes from the bank look-ahead; when the index
	// does not move it is the value just read.
	assign next_val  = ring_rd[step_idx[BANK_W-1:0]];
	assign avg_sum   = {1'b0, x_val} + {1'b0, next_val};
	assign new_cur   = (carry == '0) ? x_val : avg_sum[SAMPLE_W:1];

	// Write the averaged entry back; keep the copied excitation when the index moves on.
	always_comb begin
		wr_a.en   = do_step;
		wr_a.pos  = step_idx;
		wr_a.data = new_cur;
		wr_b.en   = do_step && attack_on && (carry != '0);
		wr_b.pos  = idx_q;
		wr_b.data = x_val;
	end

	pss_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_base (idx_d),
		.wr_a    (wr_a),
		.wr_b    (wr_b),
		.rd_data (ring_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			phase_q  <= '0;
			attack_q <= '0;
			cur_q    <= '0;
		end else begin
			if (do_step) begin
				idx_q   <= step_idx;
				phase_q <= phase_sum[FRAC_BITS-1:0];
				cur_q   <= new_cur;
				if (attack_on) begin
					attack_q <= attack_q - ATTACK_W'(1);
				end
			end
			if (do_pluck) begin
				attack_q <= cmd.attack_length;
			end
		end
	end

	// Excitation read for the next index, forwarding a load to the same entry.
	always_ff @(posedge clk) begin
		if (do_load) begin
			exc_mem[ld_addr] <= cmd.table_value;
		end
		if (do_load && ld_addr == idx_d) begin
			exc_rd_q <= cmd.table_value;
		end else begin
			exc_rd_q <= exc_mem[idx_d];
		end
	end

	// Result of a step is the value read; a hold reports the current entry.
	assign res_raw        = do_step ? x_val : cur_q;
	assign res.sample_raw = res_raw;
	assign res.sample_pcm = (res_raw >> PCM_SHIFT) + PCM_OFFSET;
	assign push           = do_step || do_hold;
	assign head_free      = !out_valid_q || sample_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (head_free) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= push;
				end else begin
					out_valid_q  <= push;
				end
			end else if (push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// Payload moves without reset: drain the skid into the head, park new results behind.
	always_ff @(posedge clk) begin
		if (head_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign sample_valid = out_valid_q;
	assign sample       = out_q;

endmodule

`default_nettype wire

// ===== dv/plucked_string_synth_core_test.sv =====
// Self-checking testbench for the plucked-string synth core: drives step, hold, pluck and
// load requests and compares every sample against a voice predictor kept in this file.
// Depends on pss_pkg and the core RTL only.
`timescale 1ns / 1ps

module plucked_string_synth_core_test;
	import pss_pkg::*;

	localparam int HOLDOFF_CYCLES = 300;
	localparam int DRAIN_CYCLES   = 20;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_ready;
	cmd_t    cmd = '0;
	logic    sample_valid;
	logic    sample_ready = 1'b0;
	sample_t sample;

	// Voice state, two copies: [0] shadows the request stream as it is built, so that no
	// step ever copies an excitation entry that was never loaded; [1] follows accepted
	// requests and produces the expected samples.
	logic [SAMPLE_W-1:0] ring_m    [2][RING_DEPTH];
	logic [SAMPLE_W-1:0] exc_m     [2][RING_DEPTH];
	logic [IDX_W-1:0]    idx_m     [2];
	logic [PHASE_W-1:0]  phase_m   [2];
	logic [ATTACK_W-1:0] attack_m  [2];
	bit                  exc_loaded [RING_DEPTH];

	cmd_t    pending_requests[$];
	sample_t expected_samples[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int mismatches    = 0;
	int sample_cnt    = 0;
	bit holdoff_armed = 1'b0;
	bit holdoff_used;
	int holdoff_left;

	plucked_string_synth_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one request to voice copy v; return 1 and the sample when it yields one.
	function automatic bit advance_voice(input int v, input cmd_t c, output sample_t s);
		logic [SAMPLE_W-1:0] x;
		logic [PHASE_W-1:0]  sum;
		logic [IDX_W-1:0]    i;
		logic [SAMPLE_W:0]   avg;
		s = '0;
		i = idx_m[v];
		case (c.operation)
			OP_PLUCK: begin
				attack_m[v] = c.attack_length;
				return 1'b0;
			end
			OP_LOAD: begin
				exc_m[v][IDX_W'(c.table_address)] = c.table_value;
				return 1'b0;
			end
			OP_HOLD: begin
				x = ring_m[v][i];
			end
			default: begin
				// Copy the excitation while the attack lasts, then read the output.
				if (attack_m[v] != '0) begin
					ring_m[v][i] = exc_m[v][i];
					attack_m[v]  = attack_m[v] - 1'b1;
				end
				x = ring_m[v][i];
				// The sum wraps at 16 bits before the carried bits move the index.
				sum         = phase_m[v] + c.step_period;
				i           = i + IDX_W'(sum >> FRAC_BITS);
				phase_m[v]  = sum & PHASE_W'((1 << FRAC_BITS) - 1);
				idx_m[v]    = i;
				avg         = ({1'b0, x} + {1'b0, ring_m[v][i]}) >> 1;
				ring_m[v][i] = avg[SAMPLE_W-1:0];
			end
		endcase
		s.sample_raw = x;
		s.sample_pcm = (x >> PCM_SHIFT) + PCM_OFFSET;
		return 1'b1;
	endfunction

	function automatic cmd_t make_request(logic [1:0] op, int period, int attack, int addr,
			int value);
		cmd_t c;
		c.operation     = op;
		c.step_period   = PHASE_W'(period);
		c.attack_length = ATTACK_W'(attack);
		c.table_address = ADDR_W'(addr);
		c.table_value   = SAMPLE_W'(value);
		return c;
	endfunction

	function automatic cmd_t random_request();
		return make_request(2'($urandom), $urandom, $urandom, $urandom, $urandom);
	endfunction

	// Queue a request; in front of a step that would copy an unloaded excitation entry,
	// queue a load of that entry first.
	task automatic queue_request(input cmd_t c);
		sample_t dummy;
		cmd_t    fill;
		if (c.operation == OP_STEP && attack_m[0] != '0 && !exc_loaded[idx_m[0]]) begin
			fill = make_request(OP_LOAD, $urandom, $urandom, idx_m[0], $urandom);
			exc_loaded[idx_m[0]] = 1'b1;
			void'(advance_voice(0, fill, dummy));
			pending_requests.push_back(fill);
		end
		if (c.operation == OP_LOAD)
			exc_loaded[IDX_W'(c.table_address)] = 1'b1;
		void'(advance_voice(0, c, dummy));
		pending_requests.push_back(c);
	endtask

	function automatic int pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 20)
			return 65535;
		if (r < 55)
			return $urandom_range(0, 16383);
		if (r < 75)
			return $urandom_range(16384, 32767);
		return $urandom_range(0, 65535);
	endfunction

	// Mostly notes (a pluck, then a run of steps mostly at one period with some holds and
	// loads mixed in), the rest short bursts of fully random requests.
	task automatic queue_random_stretch(input int count);
		int made;
		int n;
		int r;
		int period;
		int attack;
		cmd_t c;
		made = 0;
		while (made < count) begin
			if ($urandom_range(0, 99) < 70) begin
				r = $urandom_range(0, 99);
				attack = (r < 10) ? 0 : (r < 15) ? $urandom_range(0, 65535)
					: $urandom_range(1, 48);
				c = random_request();
				c.operation     = OP_PLUCK;
				c.attack_length = ATTACK_W'(attack);
				queue_request(c);
				period = pick_period();
				n = $urandom_range(6, 40);
				for (int k = 0; k < n; k++) begin
					c = random_request();
					r = $urandom_range(0, 99);
					if (r < 8)
						c.operation = OP_HOLD;
					else if (r < 12)
						c.operation = OP_LOAD;
					else begin
						c.operation = OP_STEP;
						if (r >= 90)
							c.step_period = PHASE_W'($urandom);
						else
							c.step_period = PHASE_W'(period);
					end
					queue_request(c);
				end
				made += n + 1;
			end else begin
				n = $urandom_range(1, 6);
				for (int k = 0; k < n; k++)
					queue_request(random_request());
				made += n;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_requests.size() != 0 || expected_samples.size() != 0)
			@(negedge clk);
	endtask

	// Request driver: hold an offered request until it is taken, predict on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd       <= '0;
		end else begin : drive_request
			logic    took;
			sample_t s;
			took = cmd_valid && cmd_ready;
			if (took) begin
				if (advance_voice(1, cmd, s))
					expected_samples.push_back(s);
				void'(pending_requests.pop_front());
			end
			if (cmd_valid && !took) begin
				// hold the request until it is taken
			end else if (pending_requests.size() != 0
					&& $urandom_range(0, 99) >= send_idle_pct) begin
				cmd_valid <= 1'b1;
				cmd       <= pending_requests[0];
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, started once when armed, counted down here.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holdoff_left <= 0;
			holdoff_used <= 1'b0;
		end else if (holdoff_armed && !holdoff_used) begin
			holdoff_left <= HOLDOFF_CYCLES;
			holdoff_used <= 1'b1;
		end else if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end
	end

	// Sample monitor: compare each taken sample with the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_ready <= 1'b0;
		end else begin : collect_sample
			sample_t want;
			if (sample_valid && sample_ready) begin
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("sample %0d with none expected: raw %02h pcm %02h",
							sample_cnt, sample.sample_raw, sample.sample_pcm);
				end else begin
					want = expected_samples.pop_front();
					if (want.sample_raw !== sample.sample_raw
							|| want.sample_pcm !== sample.sample_pcm) begin
						mismatches++;
						if (mismatches <= 10)
							$display("sample %0d: raw exp %02h got %02h, pcm exp %02h got %02h",
								sample_cnt, want.sample_raw, sample.sample_raw,
								want.sample_pcm, sample.sample_pcm);
					end
				end
				sample_cnt++;
			end
			sample_ready <= (holdoff_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		for (int v = 0; v < 2; v++) begin
			for (int k = 0; k < RING_DEPTH; k++) begin
				ring_m[v][k] = '0;
				exc_m[v][k]  = '0;
			end
			idx_m[v]    = '0;
			phase_m[v]  = '0;
			attack_m[v] = '0;
		end
		for (int k = 0; k < RING_DEPTH; k++)
			exc_loaded[k] = 1'b0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles lightly, receiver heavily.
		send_idle_pct = 18;
		recv_idle_pct = 52;
		// Directed: reset ring, table extremes, attack copy, phase carry and wrap.
		queue_request(make_request(OP_HOLD, 0, 0, 0, 0));
		queue_request(make_request(OP_STEP, 0, 0, 0, 0));
		queue_request(make_request(OP_LOAD, 0, 0, 0, 255));
		queue_request(make_request(OP_LOAD, 0, 0, 255, 0));
		queue_request(make_request(OP_LOAD, 0, 0, 1, 'h80));
		queue_request(make_request(OP_LOAD, 0, 0, 2, 'h0F));
		queue_request(make_request(OP_PLUCK, 0, 2, 0, 0));
		queue_request(make_request(OP_STEP, 16384, 0, 0, 0));
		queue_request(make_request(OP_STEP, 65535, 0, 0, 0));
		queue_request(make_request(OP_STEP, 1, 0, 0, 0));
		queue_request(make_request(OP_HOLD, 65535, 65535, 255, 255));
		queue_request(make_request(OP_PLUCK, 0, 65535, 0, 0));
		queue_request(make_request(OP_STEP, 49152, 0, 0, 0));
		queue_request(make_request(OP_STEP, 16383, 0, 0, 0));
		queue_request(make_request(OP_STEP, 16383, 0, 0, 0));
		queue_request(make_request(OP_PLUCK, 65535, 0, 255, 255));
		queue_request(make_request(OP_STEP, 32768, 0, 0, 0));
		queue_request(make_request(OP_STEP, 65535, 0, 0, 0));
		queue_request(make_request(OP_STEP, 65535, 0, 0, 0));
		queue_request(make_request(OP_HOLD, 0, 0, 0, 0));
		queue_request(make_request(OP_LOAD, 0, 0, 'h55, 'hAA));
		queue_request(make_request(OP_STEP, 0, 65535, 255, 255));
		queue_random_stretch(440);
		wait_drained();

		// Swap the idling sides.
		send_idle_pct = 52;
		recv_idle_pct = 18;
		queue_random_stretch(460);
		wait_drained();

		// No idling; hold off the receiver while requests keep coming.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random_stretch(480);
		holdoff_armed = 1'b1;
		wait_drained();

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#200000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
